FILE: src/grid_component_counter_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the grid component counter
// Each macro expands to one labeled concurrent assertion that is clocked on
// clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef GRID_COMPONENT_COUNTER_ASSERT_SVH
`define GRID_COMPONENT_COUNTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GCC_ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GCC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/gcc_pkg.sv
// ----------------------------------------------------------------------------
// gcc_pkg
// Shared types and constants of the grid component counter.
// ----------------------------------------------------------------------------
`default_nettype none

package gcc_pkg;

  // Default largest lattice side.
  localparam int DEF_MAX_SIDE = 64;

  // Width of the side length register and its value after reset.
  localparam int CFG_W      = 7;
  localparam int CFG_RESET  = 64;

  // Width of the reported count and its saturation value.
  localparam int COUNT_W    = 12;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // One lattice cell as it is kept in the cell memory.
  typedef struct packed {
    logic visited;
    logic open;
    logic right;
    logic down;
  } cell_t;

  localparam int CELL_W = $bits(cell_t);

endpackage

`default_nettype wire

FILE: src/gcc_ram.sv
// ----------------------------------------------------------------------------
// gcc_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module gcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: src/grid_component_counter.sv
// A lattice of N x N cells loads at one cell per cycle while in_ready is high; the
// search then scans every start cell and follows each open cell it reaches through
// the queue, and the count appears in the cycle after the search ends.
// Throughput is set by the single read port of the cell memory, used for every
// neighbor test. Reset sets the side length to 64 and needs no clearing pass.
// ----------------------------------------------------------------------------
// grid_component_counter
// Loads a square lattice of open cells and links, then counts its connected
// groups with a breadth-first search over a cell memory and a queue memory.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_component_counter #(
  parameter int MAX_SIDE = gcc_pkg::DEF_MAX_SIDE
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // Configuration
  input  wire logic                       cfg_we,
  input  wire logic [gcc_pkg::CFG_W-1:0]  cfg_wdata,
  // Input channel
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       in_site_open,
  input  wire logic                       in_right_open,
  input  wire logic                       in_down_open,
  // Result channel
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [gcc_pkg::COUNT_W-1:0]     out_component_count
);

  import gcc_pkg::*;

  `include "grid_component_counter_assert.svh"

  localparam int CELL_CAP  = MAX_SIDE * MAX_SIDE;
  localparam int CW        = $clog2(CELL_CAP);
  localparam int RW        = $clog2(MAX_SIDE);
  localparam int SW        = $clog2(MAX_SIDE + 1);
  localparam int QW        = CW + 2 * RW;
  localparam int RST_SIDE  = (CFG_RESET > MAX_SIDE) ? MAX_SIDE : CFG_RESET;

  // Controller states.
  localparam logic [2:0] ST_LOAD    = 3'd0;
  localparam logic [2:0] ST_SCAN_RD = 3'd1;
  localparam logic [2:0] ST_SCAN_CK = 3'd2;
  localparam logic [2:0] ST_POP_RD  = 3'd3;
  localparam logic [2:0] ST_POP_WT  = 3'd4;
  localparam logic [2:0] ST_CUR     = 3'd5;
  localparam logic [2:0] ST_NB_RD   = 3'd6;
  localparam logic [2:0] ST_NB_CK   = 3'd7;

  // Neighbor directions, visited in this order.
  localparam logic [1:0] DIR_RIGHT = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_UP    = 2'd3;

  // Registers.
  logic [2:0]         state_r,     state_nxt;
  logic [CW-1:0]      pos_r,       pos_nxt;
  logic [RW-1:0]      side_m1_r,   side_m1_nxt;
  logic [CW-1:0]      last_r,      last_nxt;
  logic [CW-1:0]      start_r,     start_nxt;
  logic [RW-1:0]      srow_r,      srow_nxt;
  logic [RW-1:0]      scol_r,      scol_nxt;
  logic [COUNT_W-1:0] groups_r,    groups_nxt;
  logic [CW:0]        head_r,      head_nxt;
  logic [CW:0]        tail_r,      tail_nxt;
  logic [CW-1:0]      cur_cell_r,  cur_cell_nxt;
  logic [RW-1:0]      cur_row_r,   cur_row_nxt;
  logic [RW-1:0]      cur_col_r,   cur_col_nxt;
  logic               cur_right_r, cur_right_nxt;
  logic               cur_down_r,  cur_down_nxt;
  logic [1:0]         dir_r,       dir_nxt;
  logic [CW-1:0]      nb_cell_r,   nb_cell_nxt;
  logic [RW-1:0]      nb_row_r,    nb_row_nxt;
  logic [RW-1:0]      nb_col_r,    nb_col_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;

  // Memory ports.
  logic               g_we;
  logic [CW-1:0]      g_waddr;
  cell_t              g_wdata;
  logic [CW-1:0]      g_raddr;
  cell_t              g_rdata;
  logic [CELL_W-1:0]  g_rdata_raw;
  logic               q_we;
  logic [CW-1:0]      q_waddr;
  logic [QW-1:0]      q_wdata;
  logic [CW-1:0]      q_raddr;
  logic [QW-1:0]      q_rdata;

  // Configuration decode: clamp the side and precompute the last cell index.
  logic [31:0]        cfg_ext;
  logic [31:0]        cfg_side32;
  logic [SW-1:0]      cfg_side;
  logic [2*SW-1:0]    cfg_sq;

  assign cfg_ext    = {{(32 - CFG_W){1'b0}}, cfg_wdata};
  assign cfg_side32 = (cfg_ext == 32'd0) ? 32'd1 :
                      (cfg_ext > MAX_SIDE) ? 32'(MAX_SIDE) : cfg_ext;
  assign cfg_side   = SW'(cfg_side32);
  assign cfg_sq     = {{SW{1'b0}}, cfg_side} * {{SW{1'b0}}, cfg_side};

  // Neighbor selection for the current direction.
  logic               nb_ok;
  logic [CW-1:0]      nb_cell;
  logic [RW-1:0]      nb_row;
  logic [RW-1:0]      nb_col;
  logic [CW-1:0]      side_cw;

  assign side_cw = CW'(side_m1_r) + CW'(1);

  always_comb begin
    nb_ok   = 1'b0;
    nb_cell = cur_cell_r;
    nb_row  = cur_row_r;
    nb_col  = cur_col_r;
    case (dir_r)
      DIR_RIGHT: begin
        nb_ok   = (cur_col_r != side_m1_r) && cur_right_r;
        nb_cell = cur_cell_r + CW'(1);
        nb_col  = cur_col_r + RW'(1);
      end
      DIR_LEFT: begin
        nb_ok   = (cur_col_r != '0);
        nb_cell = cur_cell_r - CW'(1);
        nb_col  = cur_col_r - RW'(1);
      end
      DIR_DOWN: begin
        nb_ok   = (cur_row_r != side_m1_r) && cur_down_r;
        nb_cell = cur_cell_r + side_cw;
        nb_row  = cur_row_r + RW'(1);
      end
      DIR_UP: begin
        nb_ok   = (cur_row_r != '0);
        nb_cell = cur_cell_r - side_cw;
        nb_row  = cur_row_r - RW'(1);
      end
      default: begin
        nb_ok   = 1'b0;
      end
    endcase
  end

  assign g_rdata = cell_t'(g_rdata_raw);

  // Main controller.
  logic step_dir;
  logic node_end;
  logic adv;
  logic link_ok;

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    side_m1_nxt   = side_m1_r;
    last_nxt      = last_r;
    start_nxt     = start_r;
    srow_nxt      = srow_r;
    scol_nxt      = scol_r;
    groups_nxt    = groups_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    cur_cell_nxt  = cur_cell_r;
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    cur_right_nxt = cur_right_r;
    cur_down_nxt  = cur_down_r;
    dir_nxt       = dir_r;
    nb_cell_nxt   = nb_cell_r;
    nb_row_nxt    = nb_row_r;
    nb_col_nxt    = nb_col_r;
    out_valid_nxt = out_valid_r;
    out_count_nxt = out_count_r;
    in_ready      = 1'b0;
    g_we          = 1'b0;
    g_waddr       = pos_r;
    g_wdata       = '0;
    g_raddr       = start_r;
    q_we          = 1'b0;
    q_waddr       = tail_r[CW-1:0];
    q_wdata       = {start_r, srow_r, scol_r};
    q_raddr       = head_r[CW-1:0];
    step_dir      = 1'b0;
    node_end      = 1'b0;
    adv           = 1'b0;
    link_ok       = 1'b1;

    // Result beat leaves on the output handshake.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      // Store one cell per beat; a lattice is not completed while a count waits.
      ST_LOAD: begin
        in_ready = !(out_valid_r && (pos_r == last_r));
        if (in_valid && in_ready) begin
          g_we          = 1'b1;
          g_waddr       = pos_r;
          g_wdata.visited = 1'b0;
          g_wdata.open  = in_site_open;
          g_wdata.right = in_right_open;
          g_wdata.down  = in_down_open;
          if (pos_r == last_r) begin
            pos_nxt    = '0;
            start_nxt  = '0;
            srow_nxt   = '0;
            scol_nxt   = '0;
            groups_nxt = '0;
            state_nxt  = ST_SCAN_RD;
          end else begin
            pos_nxt = pos_r + CW'(1);
          end
        end
      end

      ST_SCAN_RD: begin
        g_raddr   = start_r;
        state_nxt = ST_SCAN_CK;
      end

      // An open unvisited start cell opens a new group.
      ST_SCAN_CK: begin
        if (g_rdata.open && !g_rdata.visited) begin
          g_we            = 1'b1;
          g_waddr         = start_r;
          g_wdata         = g_rdata;
          g_wdata.visited = 1'b1;
          if (groups_r != COUNT_MAX) begin
            groups_nxt = groups_r + COUNT_W'(1);
          end
          q_we      = 1'b1;
          q_waddr   = '0;
          q_wdata   = {start_r, srow_r, scol_r};
          head_nxt  = '0;
          tail_nxt  = (CW + 1)'(1);
          state_nxt = ST_POP_RD;
        end else begin
          adv = 1'b1;
        end
      end

      ST_POP_RD: begin
        q_raddr   = head_r[CW-1:0];
        head_nxt  = head_r + (CW + 1)'(1);
        state_nxt = ST_POP_WT;
      end

      // Queue entry arrives; fetch the cell for its own links.
      ST_POP_WT: begin
        cur_cell_nxt = q_rdata[QW-1 -: CW];
        cur_row_nxt  = q_rdata[2*RW-1 -: RW];
        cur_col_nxt  = q_rdata[RW-1:0];
        g_raddr      = q_rdata[QW-1 -: CW];
        state_nxt    = ST_CUR;
      end

      ST_CUR: begin
        cur_right_nxt = g_rdata.right;
        cur_down_nxt  = g_rdata.down;
        dir_nxt       = DIR_RIGHT;
        state_nxt     = ST_NB_RD;
      end

      // Read the neighbor if the border allows it and, for right and down, the local link.
      ST_NB_RD: begin
        if (nb_ok) begin
          g_raddr     = nb_cell;
          nb_cell_nxt = nb_cell;
          nb_row_nxt  = nb_row;
          nb_col_nxt  = nb_col;
          state_nxt   = ST_NB_CK;
        end else begin
          step_dir = 1'b1;
        end
      end

      // Left and up links live in the neighbor's own entry.
      ST_NB_CK: begin
        if (dir_r == DIR_LEFT) begin
          link_ok = g_rdata.right;
        end else if (dir_r == DIR_UP) begin
          link_ok = g_rdata.down;
        end
        if (link_ok && g_rdata.open && !g_rdata.visited) begin
          g_we            = 1'b1;
          g_waddr         = nb_cell_r;
          g_wdata         = g_rdata;
          g_wdata.visited = 1'b1;
          q_we            = 1'b1;
          q_waddr         = tail_r[CW-1:0];
          q_wdata         = {nb_cell_r, nb_row_r, nb_col_r};
          tail_nxt        = tail_r + (CW + 1)'(1);
        end
        step_dir = 1'b1;
      end

      default: begin
        state_nxt = ST_LOAD;
      end
    endcase

    // Next direction, or the end of this cell's neighbors.
    if (step_dir) begin
      if (dir_r == DIR_UP) begin
        node_end = 1'b1;
      end else begin
        dir_nxt   = dir_r + 2'd1;
        state_nxt = ST_NB_RD;
      end
    end

    // An empty queue closes the group.
    if (node_end) begin
      if (head_r == tail_nxt) begin
        adv = 1'b1;
      end else begin
        state_nxt = ST_POP_RD;
      end
    end

    // Move the scan to the next start cell, or report the count.
    if (adv) begin
      if (start_r == last_r) begin
        out_valid_nxt = 1'b1;
        out_count_nxt = groups_nxt;
        state_nxt     = ST_LOAD;
      end else begin
        start_nxt = start_r + CW'(1);
        if (scol_r == side_m1_r) begin
          scol_nxt = '0;
          srow_nxt = srow_r + RW'(1);
        end else begin
          scol_nxt = scol_r + RW'(1);
        end
        state_nxt = ST_SCAN_RD;
      end
    end

    // A register write sets the side and last cell index and resets the load position.
    if (cfg_we) begin
      side_m1_nxt = RW'(cfg_side32 - 32'd1);
      last_nxt    = CW'(cfg_sq - 1'b1);
      pos_nxt     = '0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      pos_r       <= '0;
      side_m1_r   <= RW'(RST_SIDE - 1);
      last_r      <= CW'(RST_SIDE * RST_SIDE - 1);
      head_r      <= '0;
      tail_r      <= '0;
      dir_r       <= DIR_RIGHT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      side_m1_r   <= side_m1_nxt;
      last_r      <= last_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      dir_r       <= dir_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    start_r     <= start_nxt;
    srow_r      <= srow_nxt;
    scol_r      <= scol_nxt;
    groups_r    <= groups_nxt;
    cur_cell_r  <= cur_cell_nxt;
    cur_row_r   <= cur_row_nxt;
    cur_col_r   <= cur_col_nxt;
    cur_right_r <= cur_right_nxt;
    cur_down_r  <= cur_down_nxt;
    nb_cell_r   <= nb_cell_nxt;
    nb_row_r    <= nb_row_nxt;
    nb_col_r    <= nb_col_nxt;
    out_count_r <= out_count_nxt;
  end

  // Cell memory: open bit, both links and the visited mark.
  gcc_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_CAP)
  ) u_cell_ram (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (g_wdata),
    .raddr (g_raddr),
    .rdata (g_rdata_raw)
  );

  // Search queue: cell index with its row and column.
  gcc_ram #(
    .WIDTH (QW),
    .DEPTH (CELL_CAP)
  ) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  assign out_valid           = out_valid_r;
  assign out_component_count = out_count_r;

  // Checks on the controller.
  `GCC_ASSERT_IMPLY(a_no_overrun, in_valid && in_ready && out_valid_r, pos_r != last_r, "lattice completed while a count was pending")
  `GCC_ASSERT_IMPLY(a_ready_in_load, in_ready, state_r == ST_LOAD, "input ready outside the load phase")
  `GCC_ASSERT_IMPLY(a_queue_order, state_r != ST_LOAD, head_r <= tail_r, "queue head passed its tail")
  `GCC_ASSERT_NEXT(a_count_on_end, (state_r != ST_LOAD) && (state_nxt == ST_LOAD), out_valid_r, "search ended without a count")

endmodule

`default_nettype wire
